### rtl/dqs_pkg.sv
package dqs_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_BACK   = 3'd3;
    localparam logic [2:0] FN_SEARCH     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]        func;
        logic [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        logic              found;
        logic              now_empty;
        logic [1:0]        status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic exec;
        logic pop_load;
        logic scan_step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pop_ok;
        logic is_search;
        logic scan_done;
    } t_dp_stat;

    // Circular slot index: base plus offset, wrapped once at DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
                                                   logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

### rtl/dqs_datapath.sv
module dqs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dqs_pkg::t_dp_cmd  i_cmd,
    input  dqs_pkg::t_in_item i_item,
    output dqs_pkg::t_dp_stat o_stat,
    output dqs_pkg::t_out_item o_res
);

    logic [dqs_pkg::DATA_W-1:0] mem [dqs_pkg::DEPTH];

    logic [dqs_pkg::ADDR_W-1:0] r_head, n_head;
    logic [dqs_pkg::CNT_W-1:0]  r_occ, n_occ;
    logic [dqs_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [dqs_pkg::DATA_W-1:0] r_key;
    logic [dqs_pkg::DATA_W-1:0] r_rd_data;
    dqs_pkg::t_out_item         r_res;

    logic                       full, empty;
    logic                       wr_en;
    logic [dqs_pkg::ADDR_W-1:0] wr_addr, op_rd_addr, scan_addr, rd_addr;
    logic [1:0]                 status;
    logic                       scan_issue, hit;

    assign full  = (r_occ == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
    assign empty = (r_occ == '0);

    // Decode the operation: pointer update, write slot, read slot, status
    always_comb begin
        n_head     = r_head;
        n_occ      = r_occ;
        wr_en      = 1'b0;
        wr_addr    = r_head;
        op_rd_addr = r_head;
        status     = dqs_pkg::ST_OK;
        unique case (i_item.func)
            dqs_pkg::FN_PUSH_FRONT: begin
                if (full) begin
                    status = dqs_pkg::ST_FULL;
                end else begin
                    n_head  = (r_head == '0) ? dqs_pkg::ADDR_W'(dqs_pkg::DEPTH - 1)
                                             : r_head - 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                    n_occ   = r_occ + 1'b1;
                end
            end
            dqs_pkg::FN_PUSH_BACK: begin
                if (full) begin
                    status = dqs_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = dqs_pkg::wrap_add(r_head, r_occ);
                    n_occ   = r_occ + 1'b1;
                end
            end
            dqs_pkg::FN_POP_FRONT: begin
                if (empty) begin
                    status = dqs_pkg::ST_EMPTY;
                end else begin
                    op_rd_addr = r_head;
                    n_head     = dqs_pkg::wrap_add(r_head, dqs_pkg::CNT_W'(1));
                    n_occ      = r_occ - 1'b1;
                end
            end
            dqs_pkg::FN_POP_BACK: begin
                if (empty) begin
                    status = dqs_pkg::ST_EMPTY;
                end else begin
                    op_rd_addr = dqs_pkg::wrap_add(r_head, r_occ - 1'b1);
                    n_occ      = r_occ - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Scan walks from the front, one slot per cycle
    assign scan_issue = (r_idx < r_occ);
    assign scan_addr  = dqs_pkg::wrap_add(r_head, r_idx);
    assign rd_addr    = i_cmd.exec ? op_rd_addr : scan_addr;
    assign hit        = r_cmp_vld && (r_rd_data == r_key);

    always_comb begin
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        if (i_cmd.exec) begin
            n_idx     = '0;
            n_cmp_vld = 1'b0;
        end else if (i_cmd.scan_step) begin
            n_cmp_vld = scan_issue;
            if (scan_issue) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    // Entry store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= i_item.value;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Queue pointers and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_occ     <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head <= n_head;
                r_occ  <= n_occ;
            end
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Search key and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_key           <= i_item.value;
            r_res.popped    <= '0;
            r_res.found     <= 1'b0;
            r_res.now_empty <= (n_occ == '0);
            r_res.status    <= status;
        end else begin
            if (i_cmd.pop_load) begin
                r_res.popped <= r_rd_data;
            end
            if (i_cmd.scan_step && hit) begin
                r_res.found <= 1'b1;
            end
        end
    end

    assign o_stat.pop_ok    = ((i_item.func == dqs_pkg::FN_POP_FRONT) ||
                               (i_item.func == dqs_pkg::FN_POP_BACK)) && !empty;
    assign o_stat.is_search = (i_item.func == dqs_pkg::FN_SEARCH);
    // Done on a match, or once the last entry is under compare
    assign o_stat.scan_done = hit || !scan_issue;
    assign o_res            = r_res;

endmodule

### rtl/dqs_ctrl.sv
module dqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  dqs_pkg::t_dp_stat i_stat,
    output dqs_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Sequence one operation at a time
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.pop_ok) begin
                        n_state = S_POP;
                    end else if (i_stat.is_search) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

### rtl/double_ended_queue_with_search.sv
// A push, an unused code or a pop from an empty queue goes from the input transfer
// straight to the result; a pop that removes an entry first loads the registered read;
// a search walks one entry per cycle through the single read port of the store.
// One operation in flight: the next transfer is taken the cycle after the result leaves.
// Reset (i_rst_n low, synchronous) empties the queue; stored entries are not cleared.
module double_ended_queue_with_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dqs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dqs_pkg::t_out_item o_out_data
);

    dqs_pkg::t_dp_cmd  cmd;
    dqs_pkg::t_dp_stat stat;

    dqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dqs_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_data),
        .o_stat  (stat),
        .o_res   (o_out_data)
    );

endmodule
